FILE: rtl/core/btd_pkg.sv
package btd_pkg;

    localparam int ST_W      = 40;
    localparam int ST_FRAC   = 8;
    localparam int COEF_W    = 33;
    localparam int CFG_W     = 32;
    localparam int OFS_W     = 16;
    localparam int SHIFT_W   = 4;
    localparam int IDX_W     = 3;
    localparam int SPLIT     = 20;
    localparam int MUL_B_W   = ST_W - SPLIT + 1;
    localparam int PROD_W    = COEF_W + MUL_B_W;
    localparam int ACC_W     = COEF_W + ST_W + 1;

    localparam logic signed [CFG_W-1:0]   BP_GAIN_RST    = 32'sd7676238;
    localparam logic signed [CFG_W-1:0]   BP_FB1_RST     = -32'sd2109935000;
    localparam logic signed [CFG_W-1:0]   BP_FB2_RST     = 32'sd1058390000;
    localparam logic signed [CFG_W-1:0]   LP_GAIN_RST    = 32'sd94121;
    localparam logic signed [CFG_W-1:0]   LP_FB1_RST     = -32'sd2118862000;
    localparam logic signed [CFG_W-1:0]   LP_FB2_RST     = 32'sd1045493000;
    localparam logic signed [OFS_W-1:0]   ENV_OFFSET_RST = -16'sd20000;
    localparam logic        [SHIFT_W-1:0] ENV_SHIFT_RST  = 4'd3;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MLO  = 6'b000010,
        S_MHI  = 6'b000100,
        S_ACC  = 6'b001000,
        S_ENV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        OP_BP_A1 = 4'd0,
        OP_BP_A2 = 4'd1,
        OP_BP_B0 = 4'd2,
        OP_BP_B2 = 4'd3,
        OP_LP_A1 = 4'd4,
        OP_LP_A2 = 4'd5,
        OP_LP_B0 = 4'd6,
        OP_LP_B1 = 4'd7,
        OP_LP_B2 = 4'd8
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_BP_GAIN    = 3'd0,
        CFG_BP_FB1     = 3'd1,
        CFG_BP_FB2     = 3'd2,
        CFG_LP_GAIN    = 3'd3,
        CFG_LP_FB1     = 3'd4,
        CFG_LP_FB2     = 3'd5,
        CFG_ENV_OFFSET = 3'd6,
        CFG_ENV_SHIFT  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic lo;
        logic hi;
    } mac_ctrl_t;

endpackage

FILE: rtl/core/btd_if.sv
interface btd_frame_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] left_sample;
    logic signed [W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface btd_env_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] envelope_sample;
    logic signed [W-1:0] right_sample_out;

    modport source (output valid, output envelope_sample, output right_sample_out, input ready);
    modport sink   (input valid, input envelope_sample, input right_sample_out, output ready);
endinterface

FILE: rtl/core/btd_mac.sv
module btd_mac #(
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                                clk,
    input  btd_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [btd_pkg::COEF_W-1:0]   coef,
    input  logic signed [btd_pkg::ST_W-1:0]     operand,
    output logic signed [btd_pkg::ACC_W-1:0]    acc
);

    localparam int ACC_W  = btd_pkg::ACC_W;
    localparam int PROD_W = btd_pkg::PROD_W;
    localparam int MB_W   = btd_pkg::MUL_B_W;
    localparam int SPLIT  = btd_pkg::SPLIT;
    localparam int ST_W   = btd_pkg::ST_W;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [PROD_W-1:0] mul_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        if (ctrl.hi)
        begin
            mul_b = $signed({operand[ST_W-1], operand[ST_W-1:SPLIT]});
        end
        else
        begin
            mul_b = $signed({1'b0, operand[SPLIT-1:0]});
        end
        prod     = PROD_W'(coef) * PROD_W'(mul_b);
        mul_next = ctrl.lo ? prod : mul_reg;
        acc_next = ctrl.hi ? (ACC_W'(prod) <<< SPLIT) + ACC_W'(mul_reg) + RND : acc_reg;
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/core/biquad_tone_envelope_detector_top.sv
// Tone envelope detector. Each stereo frame taken on frame_ch runs the left sample through a
// bandpass biquad, rectifies, scales and offsets it, smooths it with a lowpass biquad and
// returns the saturated envelope on result_ch together with the unchanged right sample.
// All nine coefficient products of a frame go through one shared 33 x 21 bit multiplier,
// two passes and one accumulate step each. A new frame is accepted only once the previous
// frame's result has been loaded into result_ch. result_ch has its own register, so a pending
// result does not hold up the next frame until its own result is ready. Coefficients and
// offsets must be written on the cfg port only while no frame is in flight; the block itself
// does not enforce this. They then take effect on the next frame.
module biquad_tone_envelope_detector_top #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    btd_frame_if.sink                            frame_ch,
    btd_env_if.source                            result_ch,
    input  logic                                 cfg_we,
    input  logic [btd_pkg::IDX_W-1:0]            cfg_index,
    input  logic [btd_pkg::CFG_W-1:0]            cfg_data
);

    localparam int ST_W    = btd_pkg::ST_W;
    localparam int ACC_W   = btd_pkg::ACC_W;
    localparam int COEF_W  = btd_pkg::COEF_W;
    localparam int CFG_W   = btd_pkg::CFG_W;
    localparam int OFS_W   = btd_pkg::OFS_W;
    localparam int FRAC    = btd_pkg::ST_FRAC;
    localparam int SUM_W   = ACC_W + 2 - COEF_FRAC_BITS;
    localparam int Q_W     = ST_W - FRAC;
    localparam logic signed [Q_W-1:0] SMAX = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0] SMIN = ~SMAX;

    btd_pkg::state_t state_reg, state_next;
    btd_pkg::op_t    op_reg, op_next;

    logic signed [CFG_W-1:0]          bp_gain_reg, bp_fb1_reg, bp_fb2_reg;
    logic signed [CFG_W-1:0]          lp_gain_reg, lp_fb1_reg, lp_fb2_reg;
    logic signed [COEF_W-1:0]         bp_gain_neg_reg;
    logic signed [OFS_W-1:0]          env_offset_reg;
    logic [btd_pkg::SHIFT_W-1:0]      env_shift_reg;

    logic signed [ST_W-1:0]  bp_w0_reg, bp_w0_next, bp_w1_reg, bp_w1_next;
    logic signed [ST_W-1:0]  lp_w0_reg, lp_w0_next, lp_w1_reg, lp_w1_next;
    logic signed [ST_W-1:0]  d_reg, d_next, y_reg, y_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] right_reg, right_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_env_reg, out_env_next;
    logic signed [SAMPLE_BITS-1:0] out_right_reg, out_right_next;

    btd_pkg::mac_ctrl_t        mac_ctrl;
    logic signed [COEF_W-1:0]  coef;
    logic signed [ST_W-1:0]    operand;
    logic                      subtract;
    logic signed [ACC_W-1:0]   acc;
    logic signed [SUM_W-1:0]   prod_q;
    logic signed [SUM_W-1:0]   sum_calc;
    logic signed [ST_W-1:0]    sum_sat;
    logic [ST_W:0]             mag;
    logic [ST_W:0]             mag_shift;
    logic signed [SUM_W-1:0]   env_sum;
    logic signed [ST_W-1:0]    env_sat;
    logic signed [ST_W-1:0]    y_bias;
    logic signed [Q_W-1:0]     q;
    logic signed [SAMPLE_BITS-1:0] q_sat;
    logic                      frame_xfer;

    function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SUM_W-1:0] v);
        logic fits;
        fits = (&v[SUM_W-1:ST_W-1]) | ~(|v[SUM_W-1:ST_W-1]);
        if (fits)
        begin
            return v[ST_W-1:0];
        end
        return {v[SUM_W-1], {(ST_W - 1){~v[SUM_W-1]}}};
    endfunction

    assign frame_xfer     = frame_ch.valid && frame_ch.ready;
    assign frame_ch.ready = (state_reg == btd_pkg::S_IDLE);

    assign result_ch.valid            = out_valid_reg;
    assign result_ch.envelope_sample  = out_env_reg;
    assign result_ch.right_sample_out = out_right_reg;

    assign mac_ctrl.lo = (state_reg == btd_pkg::S_MLO);
    assign mac_ctrl.hi = (state_reg == btd_pkg::S_MHI);

    btd_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .coef    (coef),
        .operand (operand),
        .acc     (acc)
    );

    always_comb
    begin
        coef     = COEF_W'(bp_fb1_reg);
        operand  = bp_w0_reg;
        subtract = 1'b1;
        case (op_reg)
            btd_pkg::OP_BP_A1:
            begin
                coef    = COEF_W'(bp_fb1_reg);
                operand = bp_w0_reg;
            end
            btd_pkg::OP_BP_A2:
            begin
                coef    = COEF_W'(bp_fb2_reg);
                operand = bp_w1_reg;
            end
            btd_pkg::OP_BP_B0:
            begin
                coef     = COEF_W'(bp_gain_reg);
                operand  = d_reg;
                subtract = 1'b0;
            end
            btd_pkg::OP_BP_B2:
            begin
                coef     = bp_gain_neg_reg;
                operand  = bp_w1_reg;
                subtract = 1'b0;
            end
            btd_pkg::OP_LP_A1:
            begin
                coef    = COEF_W'(lp_fb1_reg);
                operand = lp_w0_reg;
            end
            btd_pkg::OP_LP_A2:
            begin
                coef    = COEF_W'(lp_fb2_reg);
                operand = lp_w1_reg;
            end
            btd_pkg::OP_LP_B0:
            begin
                coef     = COEF_W'(lp_gain_reg);
                operand  = d_reg;
                subtract = 1'b0;
            end
            btd_pkg::OP_LP_B1:
            begin
                coef     = COEF_W'(lp_gain_reg) <<< 1;
                operand  = lp_w0_reg;
                subtract = 1'b0;
            end
            btd_pkg::OP_LP_B2:
            begin
                coef     = COEF_W'(lp_gain_reg);
                operand  = lp_w1_reg;
                subtract = 1'b0;
            end
            default:
            begin
                coef     = COEF_W'(bp_fb1_reg);
                operand  = bp_w0_reg;
                subtract = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        prod_q    = SUM_W'($signed(acc[ACC_W-1:COEF_FRAC_BITS]));
        sum_calc  = subtract ? sum_reg - prod_q : sum_reg + prod_q;
        sum_sat   = sat_st(sum_calc);

        mag       = y_reg[ST_W-1] ? (ST_W + 1)'(0) - (ST_W + 1)'(y_reg) : (ST_W + 1)'(y_reg);
        mag_shift = mag >> env_shift_reg;
        env_sum   = SUM_W'($signed({1'b0, mag_shift})) + (SUM_W'(env_offset_reg) <<< FRAC);
        env_sat   = sat_st(env_sum);

        y_bias    = y_reg + (y_reg[ST_W-1] ? ST_W'((1 << FRAC) - 1) : ST_W'(0));
        q         = y_bias[ST_W-1:FRAC];
        if (q > SMAX)
        begin
            q_sat = SMAX[SAMPLE_BITS-1:0];
        end
        else if (q < SMIN)
        begin
            q_sat = SMIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            q_sat = q[SAMPLE_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        sum_next       = sum_reg;
        d_next         = d_reg;
        y_next         = y_reg;
        bp_w0_next     = bp_w0_reg;
        bp_w1_next     = bp_w1_reg;
        lp_w0_next     = lp_w0_reg;
        lp_w1_next     = lp_w1_reg;
        right_next     = right_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        out_env_next   = out_env_reg;
        out_right_next = out_right_reg;

        case (state_reg)
            btd_pkg::S_IDLE:
            begin
                if (frame_xfer)
                begin
                    sum_next   = SUM_W'(SAMPLE_BITS'(frame_ch.left_sample)) <<< FRAC;
                    right_next = SAMPLE_BITS'(frame_ch.right_sample);
                    op_next    = btd_pkg::OP_BP_A1;
                    state_next = btd_pkg::S_MLO;
                end
            end
            btd_pkg::S_MLO:
            begin
                state_next = btd_pkg::S_MHI;
            end
            btd_pkg::S_MHI:
            begin
                state_next = btd_pkg::S_ACC;
            end
            btd_pkg::S_ACC:
            begin
                op_next    = btd_pkg::op_t'(op_reg + 4'd1);
                state_next = btd_pkg::S_MLO;
                case (op_reg)
                    btd_pkg::OP_BP_A2, btd_pkg::OP_LP_A2:
                    begin
                        d_next   = sum_sat;
                        sum_next = '0;
                    end
                    btd_pkg::OP_BP_B2:
                    begin
                        y_next     = sum_sat;
                        bp_w1_next = bp_w0_reg;
                        bp_w0_next = d_reg;
                        state_next = btd_pkg::S_ENV;
                    end
                    btd_pkg::OP_LP_B2:
                    begin
                        y_next     = sum_sat;
                        lp_w1_next = lp_w0_reg;
                        lp_w0_next = d_reg;
                        op_next    = btd_pkg::OP_BP_A1;
                        state_next = btd_pkg::S_OUT;
                    end
                    default:
                    begin
                        sum_next = sum_calc;
                    end
                endcase
            end
            btd_pkg::S_ENV:
            begin
                sum_next   = SUM_W'(env_sat);
                state_next = btd_pkg::S_MLO;
            end
            btd_pkg::S_OUT:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_env_next   = q_sat;
                    out_right_next = right_reg;
                    state_next     = btd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = btd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btd_pkg::S_IDLE;
            op_reg        <= btd_pkg::OP_BP_A1;
            out_valid_reg <= 1'b0;
            bp_w0_reg     <= '0;
            bp_w1_reg     <= '0;
            lp_w0_reg     <= '0;
            lp_w1_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            bp_w0_reg     <= bp_w0_next;
            bp_w1_reg     <= bp_w1_next;
            lp_w0_reg     <= lp_w0_next;
            lp_w1_reg     <= lp_w1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        d_reg         <= d_next;
        y_reg         <= y_next;
        right_reg     <= right_next;
        out_env_reg   <= out_env_next;
        out_right_reg <= out_right_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_gain_reg     <= btd_pkg::BP_GAIN_RST;
            bp_gain_neg_reg <= -COEF_W'(btd_pkg::BP_GAIN_RST);
            bp_fb1_reg      <= btd_pkg::BP_FB1_RST;
            bp_fb2_reg      <= btd_pkg::BP_FB2_RST;
            lp_gain_reg     <= btd_pkg::LP_GAIN_RST;
            lp_fb1_reg      <= btd_pkg::LP_FB1_RST;
            lp_fb2_reg      <= btd_pkg::LP_FB2_RST;
            env_offset_reg  <= btd_pkg::ENV_OFFSET_RST;
            env_shift_reg   <= btd_pkg::ENV_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (btd_pkg::cfg_idx_t'(cfg_index))
                btd_pkg::CFG_BP_GAIN:
                begin
                    bp_gain_reg     <= $signed(cfg_data);
                    bp_gain_neg_reg <= -COEF_W'($signed(cfg_data));
                end
                btd_pkg::CFG_BP_FB1:     bp_fb1_reg     <= $signed(cfg_data);
                btd_pkg::CFG_BP_FB2:     bp_fb2_reg     <= $signed(cfg_data);
                btd_pkg::CFG_LP_GAIN:    lp_gain_reg    <= $signed(cfg_data);
                btd_pkg::CFG_LP_FB1:     lp_fb1_reg     <= $signed(cfg_data);
                btd_pkg::CFG_LP_FB2:     lp_fb2_reg     <= $signed(cfg_data);
                btd_pkg::CFG_ENV_OFFSET: env_offset_reg <= $signed(cfg_data[OFS_W-1:0]);
                btd_pkg::CFG_ENV_SHIFT:  env_shift_reg  <= cfg_data[btd_pkg::SHIFT_W-1:0];
                default:
                begin
                    env_shift_reg <= env_shift_reg;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
        frame_xfer |=> (state_reg == btd_pkg::S_MLO) && (op_reg == btd_pkg::OP_BP_A1))
        else $error("frame transfer did not start the first product");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == btd_pkg::S_OUT)
        else $error("result raised outside the output step");

    a_env_after_bp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == btd_pkg::S_ENV) |->
            ($past(state_reg) == btd_pkg::S_ACC) && ($past(op_reg) == btd_pkg::OP_BP_B2))
        else $error("envelope step entered out of sequence");

    a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != btd_pkg::S_IDLE) |-> (op_reg <= btd_pkg::OP_LP_B2))
        else $error("product index out of range");

    a_idle_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == btd_pkg::S_OUT) |-> (op_reg == btd_pkg::OP_BP_A1) && (y_reg == $past(y_reg)
            || $past(state_reg) == btd_pkg::S_ACC))
        else $error("result value changed while waiting to be taken");
`endif

endmodule

FILE: tb/sv/biquad_tone_envelope_detector_top_tb.sv
module biquad_tone_envelope_detector_top_tb;

    localparam int     FRAC_BITS   = 30;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     DRAIN       = 40;
    localparam longint ACC_MAX     = (longint'(1) <<< 39) - 1;
    localparam longint ACC_MIN     = -ACC_MAX - 1;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } frame_t;

    typedef struct packed {
        logic signed [15:0] envelope;
        logic signed [15:0] right;
    } env_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    btd_pkg::cfg_idx_t         cfg_index;
    logic [btd_pkg::CFG_W-1:0] cfg_data;

    btd_frame_if #(.W(16)) frame_ch ();
    btd_env_if   #(.W(16)) result_ch ();

    biquad_tone_envelope_detector_top #(
        .SAMPLE_BITS    (16),
        .COEF_FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_ch  (frame_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // filter coefficients and envelope settings as the block should hold them
    longint      bp_b0, bp_a1, bp_a2, lp_b0, lp_a1, lp_a2, env_ofs;
    int          env_shr;
    longint      bp_w[2];
    longint      lp_w[2];

    frame_t      frame_queue[$];
    env_result_t env_expected[$];

    int          mismatches = 0;
    int          frames_sent = 0;
    int          results_checked = 0;
    int          reg_writes = 0;
    int          settings_used = 1;
    int unsigned cycle_count = 0;

    bit          src_quiet = 1'b0;
    bit          snk_quiet = 1'b0;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          send_wait = 0;
    int          recv_wait = 0;
    frame_t      next_frame;
    env_result_t want;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint clamp40(longint v);
        if (v > ACC_MAX)
            return ACC_MAX;
        if (v < ACC_MIN)
            return ACC_MIN;
        return v;
    endfunction

    // rounded coefficient product, split so that nothing overflows 64 bits
    function automatic longint coef_mul(longint c, longint s);
        longint hi;
        longint lo;
        longint q;
        hi = s >>> FRAC_BITS;
        lo = s - (hi <<< FRAC_BITS);
        q  = c * lo + (longint'(1) <<< (FRAC_BITS - 1));
        return c * hi + (q >>> FRAC_BITS);
    endfunction

    function automatic longint fb_node(longint x, longint a1, longint a2, longint w0,
                                       longint w1);
        return clamp40(x - coef_mul(a1, w0) - coef_mul(a2, w1));
    endfunction

    function automatic longint ff_sum(longint b0, longint b1, longint b2, longint d,
                                      longint w0, longint w1);
        return clamp40(coef_mul(b0, d) + coef_mul(b1, w0) + coef_mul(b2, w1));
    endfunction

    function env_result_t envelope_of(logic signed [15:0] left, logic signed [15:0] right);
        env_result_t r;
        longint      d;
        longint      y_bp;
        longint      mag;
        longint      env;
        longint      y_lp;
        longint      o;
        d    = fb_node(longint'(left) * 256, bp_a1, bp_a2, bp_w[0], bp_w[1]);
        y_bp = ff_sum(bp_b0, 0, -bp_b0, d, bp_w[0], bp_w[1]);
        bp_w[1] = bp_w[0];
        bp_w[0] = d;
        mag  = (y_bp < 0) ? -y_bp : y_bp;
        env  = clamp40((mag >>> env_shr) + env_ofs * 256);
        d    = fb_node(env, lp_a1, lp_a2, lp_w[0], lp_w[1]);
        y_lp = ff_sum(lp_b0, 2 * lp_b0, lp_b0, d, lp_w[0], lp_w[1]);
        lp_w[1] = lp_w[0];
        lp_w[0] = d;
        o = y_lp / 256;
        if (o > 32767)
            o = 32767;
        if (o < -32768)
            o = -32768;
        r.envelope = 16'(o);
        r.right    = right;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [31:0] pick_coef(logic [31:0] nominal);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom();
            default: return nominal + 32'($urandom_range(0, 131071)) - 32'd65536;
        endcase
    endfunction

    task automatic write_reg(btd_pkg::cfg_idx_t idx, logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        reg_writes++;
        case (idx)
            btd_pkg::CFG_BP_GAIN:    bp_b0   = longint'($signed(data));
            btd_pkg::CFG_BP_FB1:     bp_a1   = longint'($signed(data));
            btd_pkg::CFG_BP_FB2:     bp_a2   = longint'($signed(data));
            btd_pkg::CFG_LP_GAIN:    lp_b0   = longint'($signed(data));
            btd_pkg::CFG_LP_FB1:     lp_a1   = longint'($signed(data));
            btd_pkg::CFG_LP_FB2:     lp_a2   = longint'($signed(data));
            btd_pkg::CFG_ENV_OFFSET: env_ofs = longint'($signed(data[15:0]));
            btd_pkg::CFG_ENV_SHIFT:  env_shr = int'(data[3:0]);
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] g_bp, logic [31:0] f1_bp, logic [31:0] f2_bp,
                             logic [31:0] g_lp, logic [31:0] f1_lp, logic [31:0] f2_lp,
                             logic [31:0] ofs, logic [31:0] shr);
        write_reg(btd_pkg::CFG_BP_GAIN, g_bp);
        write_reg(btd_pkg::CFG_BP_FB1, f1_bp);
        write_reg(btd_pkg::CFG_BP_FB2, f2_bp);
        write_reg(btd_pkg::CFG_LP_GAIN, g_lp);
        write_reg(btd_pkg::CFG_LP_FB1, f1_lp);
        write_reg(btd_pkg::CFG_LP_FB2, f2_lp);
        write_reg(btd_pkg::CFG_ENV_OFFSET, ofs);
        write_reg(btd_pkg::CFG_ENV_SHIFT, shr);
        settings_used++;
    endtask

    task automatic push_frame(logic [15:0] l, logic [15:0] r);
        frame_t f;
        f.left  = l;
        f.right = r;
        frame_queue.push_back(f);
    endtask

    // mostly tone bursts near the passband, some noise and rail-to-rail frames
    task automatic queue_signal(int n_items);
        frame_t f;
        int     done;
        int     seg_len;
        int     kind;
        int     half;
        int     amp;
        int     v;
        int     k;
        done = 0;
        while (done < n_items)
        begin
            kind    = $urandom_range(0, 9);
            seg_len = $urandom_range(5, 50);
            half    = $urandom_range(8, 24);
            amp     = $urandom_range(0, 32000);
            for (k = 0; k < seg_len && done < n_items; k++)
            begin
                if (kind < 6)
                begin
                    v = (((k / half) % 2) != 0) ? -amp : amp;
                    v = v + $urandom_range(0, 1000) - 500;
                    f.left = 16'(v);
                end
                else if (kind < 9)
                    f.left = 16'($urandom());
                else
                    f.left = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
                f.right = 16'($urandom());
                frame_queue.push_back(f);
                done++;
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (frame_queue.size() != 0 || frame_ch.valid || env_expected.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ch.valid        <= 1'b0;
            frame_ch.left_sample  <= '0;
            frame_ch.right_sample <= '0;
            send_wait = 0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                env_expected.push_back(envelope_of(frame_ch.left_sample,
                                                   frame_ch.right_sample));
                frames_sent++;
            end
            if (!frame_ch.valid || frame_ch.ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    frame_ch.valid <= 1'b0;
                end
                else if (frame_queue.size() > 0)
                begin
                    next_frame = frame_queue.pop_front();
                    frame_ch.valid        <= 1'b1;
                    frame_ch.left_sample  <= next_frame.left;
                    frame_ch.right_sample <= next_frame.right;
                    send_wait = src_quiet ? 0 : pick_gap();
                end
                else
                    frame_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_checked++;
                if (env_expected.size() == 0)
                begin
                    $display("%0t: unexpected result envelope=%0d right=%0d", $time,
                             result_ch.envelope_sample, result_ch.right_sample_out);
                    mismatches++;
                end
                else
                begin
                    want = env_expected.pop_front();
                    if (result_ch.envelope_sample !== want.envelope)
                    begin
                        $display("%0t: envelope expected %0d got %0d", $time,
                                 want.envelope, result_ch.envelope_sample);
                        mismatches++;
                    end
                    if (result_ch.right_sample_out !== want.right)
                    begin
                        $display("%0t: right sample expected %0d got %0d", $time,
                                 want.right, result_ch.right_sample_out);
                        mismatches++;
                    end
                end
                recv_wait = snk_quiet ? 0 : pick_gap();
            end
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     env_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int ph;
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = btd_pkg::CFG_BP_GAIN;
        cfg_data               = '0;
        frame_ch.valid         = 1'b0;
        frame_ch.left_sample   = '0;
        frame_ch.right_sample  = '0;
        result_ch.ready        = 1'b0;
        bp_b0   = longint'(btd_pkg::BP_GAIN_RST);
        bp_a1   = longint'(btd_pkg::BP_FB1_RST);
        bp_a2   = longint'(btd_pkg::BP_FB2_RST);
        lp_b0   = longint'(btd_pkg::LP_GAIN_RST);
        lp_a1   = longint'(btd_pkg::LP_FB1_RST);
        lp_a2   = longint'(btd_pkg::LP_FB2_RST);
        env_ofs = longint'(btd_pkg::ENV_OFFSET_RST);
        env_shr = int'(btd_pkg::ENV_SHIFT_RST);
        bp_w    = '{0, 0};
        lp_w    = '{0, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, sample extremes
        @(negedge clk);
        push_frame(16'h0000, 16'h7fff);
        push_frame(16'h7fff, 16'h8000);
        push_frame(16'h8000, 16'h0000);
        push_frame(16'h7fff, 16'hffff);
        push_frame(16'h8000, 16'h5555);
        push_frame(16'h0001, 16'haaaa);
        push_frame(16'hffff, 16'h0001);
        push_frame(16'h7fff, 16'h8000);
        wait_idle();

        // extreme coefficients: saturation everywhere, junk in unused data bits
        write_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'hffff_7fff, 32'hffff_fff0);
        @(negedge clk);
        push_frame(16'h7fff, 16'h1234);
        push_frame(16'h8000, 16'hedcb);
        push_frame(16'h7fff, 16'h7fff);
        push_frame(16'h8000, 16'h8000);
        push_frame(16'h0000, 16'h0000);
        push_frame(16'h7fff, 16'hffff);
        push_frame(16'h8000, 16'h0000);
        wait_idle();

        write_all(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h0001_8000, 32'h0000_000f);
        @(negedge clk);
        push_frame(16'h8000, 16'h0f0f);
        push_frame(16'h7fff, 16'hf0f0);
        push_frame(16'h8000, 16'h7fff);
        push_frame(16'h7fff, 16'h8000);
        push_frame(16'h0000, 16'h0000);
        push_frame(16'h8000, 16'hffff);
        wait_idle();

        for (ph = 0; ph < 9; ph++)
        begin
            write_all(pick_coef(btd_pkg::BP_GAIN_RST), pick_coef(btd_pkg::BP_FB1_RST),
                      pick_coef(btd_pkg::BP_FB2_RST), pick_coef(btd_pkg::LP_GAIN_RST),
                      pick_coef(btd_pkg::LP_FB1_RST), pick_coef(btd_pkg::LP_FB2_RST),
                      ($urandom_range(0, 2) == 0) ? $urandom()
                                                  : 32'(btd_pkg::ENV_OFFSET_RST),
                      ($urandom_range(0, 1) == 0) ? $urandom()
                                                  : 32'(btd_pkg::ENV_SHIFT_RST));
            @(negedge clk);
            if (ph == 2)
            begin
                // hold the result side off while frames keep coming
                src_quiet = 1'b1;
                snk_quiet = 1'b1;
                hold_token++;
                queue_signal(30);
            end
            else
            begin
                src_quiet = ($urandom_range(0, 3) == 0);
                snk_quiet = ($urandom_range(0, 3) == 0);
                queue_signal(55);
            end
            wait_idle();
        end

        repeat (DRAIN) @(posedge clk);
        $display("covered %0d frames and %0d checked results over %0d register settings",
                 frames_sent, results_checked, settings_used);
        $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0 && env_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
